@@ rtl/rre_pkg.sv @@
// ----------------------------------------------------------------------------
// RTT/RTO estimator package
// Field widths, reset values and register codes shared by the estimator files.
// ----------------------------------------------------------------------------
package rre_pkg;

	localparam int unsigned SAMPLE_W      = 32;
	localparam int unsigned SRTT_W        = 16;
	localparam int unsigned RTO_W         = 19;
	localparam int unsigned FRAC_BITS_DEF = 4;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [RTO_W-1:0]  RTO_MIN_RST = RTO_W'(1000);
	localparam logic [RTO_W-1:0]  RTO_MAX_RST = RTO_W'(10000);
	localparam logic [RTO_W-1:0]  RTO_OFFSET  = RTO_W'(200);
	localparam logic [SRTT_W-1:0] SAMPLE_MAX  = {SRTT_W{1'b1}};
	localparam logic [SRTT_W-1:0] SAMPLE_MIN  = SRTT_W'(1);

	typedef enum logic {
		REG_RTO_MIN = 1'b0,
		REG_RTO_MAX = 1'b1
	} reg_idx_t;

	typedef logic [SRTT_W-1:0] srtt_t;
	typedef logic [RTO_W-1:0]  rto_t;

endpackage

@@ rtl/rre_ifs.sv @@
// ----------------------------------------------------------------------------
// RTT/RTO estimator channels
// Valid/ready channels for round-trip samples and for estimator results.
// ----------------------------------------------------------------------------
interface rre_sample_if;
	import rre_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] rtt_sample;

	modport source (output valid, output rtt_sample, input ready);
	modport sink   (input valid, input rtt_sample, output ready);
endinterface

interface rre_result_if;
	import rre_pkg::*;

	logic              valid;
	logic              ready;
	logic [SRTT_W-1:0] smoothed_rtt;
	logic [RTO_W-1:0]  timeout;

	modport source (output valid, output smoothed_rtt, output timeout, input ready);
	modport sink   (input valid, input smoothed_rtt, input timeout, output ready);
endinterface

@@ rtl/rre_core.sv @@
// ----------------------------------------------------------------------------
// RTT/RTO estimator core
// Holds smoothed RTT and variance, computes the update and the clamped timeout.
// ----------------------------------------------------------------------------
module rre_core #(
	parameter int unsigned FRAC_BITS = rre_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          upd,
	input  rre_pkg::srtt_t sample,
	input  rre_pkg::rto_t rto_min,
	input  rre_pkg::rto_t rto_max,
	output rre_pkg::srtt_t srtt_nxt,
	output rre_pkg::rto_t timeout_nxt
);
	import rre_pkg::*;

	localparam int unsigned VAR_W = SRTT_W + FRAC_BITS;
	localparam int unsigned SUM_W = VAR_W + 3;

	logic [SRTT_W-1:0]  srtt_q;
	logic [VAR_W-1:0]   var_q;
	logic [SRTT_W-1:0]  diff;
	logic [VAR_W+1:0]   vsum;
	logic [VAR_W-1:0]   var_nxt;
	logic [SRTT_W+2:0]  ssum;
	logic [SUM_W-1:0]   tsum;
	logic [RTO_W-1:0]   t_raw;

	always_comb begin
		diff = (srtt_q >= sample) ? (srtt_q - sample) : (sample - srtt_q);
		vsum = (VAR_W+2)'(var_q) + ((VAR_W+2)'(var_q) << 1)
			+ ((VAR_W+2)'(diff) << FRAC_BITS);
		if (var_q == '0) begin
			var_nxt = VAR_W'(sample) << (FRAC_BITS - 1);
		end else begin
			var_nxt = vsum[VAR_W+1:2];
		end

		ssum = ((SRTT_W+3)'(srtt_q) << 3) - (SRTT_W+3)'(srtt_q) + (SRTT_W+3)'(sample);
		priority if (srtt_q == '0) begin
			srtt_nxt = sample;
		end else if (sample != srtt_q) begin
			srtt_nxt = ssum[SRTT_W+2:3];
		end else begin
			srtt_nxt = srtt_q;
		end

		tsum = (SUM_W'(srtt_nxt) << FRAC_BITS) + (SUM_W'(var_nxt) << 2)
			+ (SUM_W'(RTO_OFFSET) << FRAC_BITS);
		t_raw = tsum[SUM_W-1 -: RTO_W];

		priority if (t_raw < rto_min) begin
			timeout_nxt = rto_min;
		end else if (t_raw > rto_max) begin
			timeout_nxt = rto_max;
		end else begin
			timeout_nxt = t_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q <= '0;
			var_q  <= '0;
		end else if (upd) begin
			srtt_q <= srtt_nxt;
			var_q  <= var_nxt;
		end
	end

endmodule

@@ rtl/rtt_rto_estimator.sv @@
// ----------------------------------------------------------------------------
// RTT/RTO estimator
// Smooths round-trip samples and derives a clamped retransmission timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the sample channel, one transfer per measurement. Each
//   sample is saturated to 1..65535 and held in an input register; from there
//   it updates the smoothed RTT and variance and loads the result register.
//   Every sample gives exactly one transfer on the result channel, carrying
//   the new smoothed RTT and the timeout clamped to rto_min and rto_max.
//   Throughput is one sample per cycle while the receiver takes results,
//   set by the single update step between the input and result registers.
//   When the receiver stalls, the result register holds and the input
//   register fills; the sample channel then deasserts ready until the result
//   is taken. No sample is dropped.
//   Reset clears the estimator state (no sample seen) and loads rto_min with
//   1000 and rto_max with 10000. The clamps are written over the APB port at
//   byte addresses 0 and 4 and should only change while the block is idle.
// ----------------------------------------------------------------------------
module rtt_rto_estimator #(
	parameter int unsigned FRAC_BITS = rre_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rre_sample_if.sink                     sample,
	rre_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rre_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rre_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rre_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import rre_pkg::*;

	rto_t       rto_min_q;
	rto_t       rto_max_q;
	reg_idx_t   reg_idx;
	logic       cfg_wr;

	logic       valid_s1;
	srtt_t      sample_s1;
	srtt_t      sample_sat;
	logic       move;

	logic       out_valid_q;
	srtt_t      smoothed_q;
	rto_t       timeout_q;
	srtt_t      srtt_nxt;
	rto_t       timeout_nxt;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			REG_RTO_MIN: prdata = APB_DATA_W'(rto_min_q);
			REG_RTO_MAX: prdata = APB_DATA_W'(rto_max_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rto_min_q <= RTO_MIN_RST;
			rto_max_q <= RTO_MAX_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RTO_MIN: rto_min_q <= pwdata[RTO_W-1:0];
				REG_RTO_MAX: rto_max_q <= pwdata[RTO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (sample.rtt_sample == '0) begin
			sample_sat = SAMPLE_MIN;
		end else if (sample.rtt_sample[SAMPLE_W-1:SRTT_W] != '0) begin
			sample_sat = SAMPLE_MAX;
		end else begin
			sample_sat = sample.rtt_sample[SRTT_W-1:0];
		end
	end

	assign move         = !out_valid_q || result.ready;
	assign sample.ready = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1 <= sample_sat;
		end
	end

	rre_core #(
		.FRAC_BITS(FRAC_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (valid_s1 && move),
		.sample      (sample_s1),
		.rto_min     (rto_min_q),
		.rto_max     (rto_max_q),
		.srtt_nxt    (srtt_nxt),
		.timeout_nxt (timeout_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && move) begin
			smoothed_q <= srtt_nxt;
			timeout_q  <= timeout_nxt;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.smoothed_rtt = smoothed_q;
	assign result.timeout      = timeout_q;

endmodule

@@ rtl/rre_checker.sv @@
// ----------------------------------------------------------------------------
// RTT/RTO estimator checker
// Port-level assertions on the estimator channels, bound to the top level.
// ----------------------------------------------------------------------------
module rre_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input rre_pkg::srtt_t         out_srtt,
	input rre_pkg::rto_t          out_timeout
);
	import rre_pkg::*;

	// A result that is not taken stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_srtt) && $stable(out_timeout))
		else $error("stalled result changed");

	// Samples are only refused while a result is waiting on the receiver.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("sample refused without a stalled result");

	// A sample transfer always leads to a result being offered.
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##2 out_valid)
		else $error("no result offered after a sample transfer");

	// The smoothed RTT is seeded from a saturated sample and never returns to zero.
	a_srtt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_srtt != '0)
		else $error("smoothed RTT of zero");

endmodule

bind rtt_rto_estimator rre_checker u_rre_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_srtt    (result.smoothed_rtt),
	.out_timeout (result.timeout)
);
